// File: design/fpc_pkg.sv
package fpc_pkg;

  localparam int MAX_PLANES = 6;
  localparam int CNT_W      = 3;
  localparam int WORD_W     = 32;
  localparam int COEF_W     = 16;
  localparam int PLANE_W    = 4 * COEF_W;

  // Q16.16 one, used for w and for the identity matrix at reset
  localparam logic signed [WORD_W-1:0] ONE_Q16 = 32'sh0001_0000;

  // stream and config port geometry
  localparam int S_TDATA_W   = 136;
  localparam int M_TDATA_W   = 8;
  localparam int ROW_LSB     = 0;
  localparam int WORD_LSB    = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // register indexes; plane k sits at index k
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TEST_MODE   = 3'd7;

  // tuser codes
  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_ROW    = 1'b1;

  // datapath widths: transformed coordinate, plane dot in mode 0 and mode 1
  localparam int T_W   = 66;
  localparam int TH_W  = T_W - 33;
  localparam int ACC_W = 83;
  localparam int DOT_W = 50;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ROW_LAST   = 5'd3;
  localparam logic [STEP_W-1:0] XFORM_ISS  = 5'd16;
  localparam logic [STEP_W-1:0] XFORM_LAST = 5'd17;
  localparam logic [STEP_W-1:0] PLANE_ISS  = 5'd24;
  localparam logic [STEP_W-1:0] PLANE_LAST = 5'd24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_XFORM,
    ST_PLANE,
    ST_FIN
  } state_t;

endpackage

// File: design/frustum_plane_cull.sv
// Row load: one matrix word per cycle in the row-write state; no new transfer is taken meanwhile.
// Vertex: 16 matrix reads through a 32x32 multiplier, then 24 plane/row steps; m_axis_tvalid
// rises only after the last vertex of a set; the next input waits until the block is idle again.
// The matrix memory, read one word per step, and the shared plane multipliers set this order.
// Reset (rst, synchronous): identity matrix, planes and count 0, mode 0, set flags clear.
module frustum_plane_cull (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] row_index, [33:2] word_0, [65:34] word_1, [97:66] word_2, [129:98] word_3
  input  logic [fpc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tlast,
  // [0] req_type
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] visible
  output logic [fpc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [fpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fpc_pkg::*;

  // config registers
  logic [PLANE_W-1:0] planes [MAX_PLANES];
  logic [CNT_W-1:0]   plane_count;
  logic               test_mode;
  logic [CNT_W-1:0]   count_eff;

  // control
  state_t            state, state_next;
  logic [STEP_W-1:0] step;
  logic              s_xfer;

  // captured item
  logic                     req_q;
  logic [1:0]               row_q;
  logic signed [WORD_W-1:0] word_q [4];
  logic                     last_q;

  // matrix memory
  logic [WORD_W-1:0] mtx_mem [16];
  logic [15:0]       mtx_written;
  logic              mem_we;
  logic [3:0]        mem_waddr;
  logic [WORD_W-1:0] rd_data_q;
  logic              rd_written_q;

  // transform pipeline
  logic                       s1_valid;
  logic [3:0]                 s1_addr;
  logic signed [WORD_W-1:0]   m_val;
  logic signed [WORD_W-1:0]   v_sel;
  logic signed [2*WORD_W-1:0] prod;
  logic                       s2_valid;
  logic [3:0]                 s2_addr;
  logic [T_W-1:0]             xf_t [4];

  // plane pipeline
  logic                      pl_issue;
  logic [CNT_W-1:0]          pl_k;
  logic [1:0]                pl_r;
  logic [PLANE_W-1:0]        plane_sel;
  logic signed [COEF_W-1:0]  coef;
  logic [T_W-1:0]            t_sel;
  logic signed [TH_W-1:0]    t_hi;
  logic signed [33:0]        t_lo;
  logic signed [WORD_W-1:0]  v_pl;
  logic signed [48:0]        ph;
  logic signed [49:0]        pl;
  logic signed [47:0]        pv;
  logic                      b_valid;
  logic [CNT_W-1:0]          b_k;
  logic [1:0]                b_r;
  logic [ACC_W-1:0]          acc_t, sum_t, term_h, term_l;
  logic [DOT_W-1:0]          acc_v, sum_v;

  // set flags
  logic [MAX_PLANES-1:0] inside_flags;
  logic                  rejected;
  logic                  rejected_new;
  logic [CNT_W-1:0]      outside_cnt;
  logic [MAX_PLANES-1:0] need;
  logic                  vis_bit;
  logic                  out_free;
  logic                  m_vis;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, m_vis};
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign count_eff = (plane_count > CNT_W'(MAX_PLANES)) ? CNT_W'(MAX_PLANES) : plane_count;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PLANES; i++) planes[i] <= '0;
      plane_count <= '0;
      test_mode   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index < REG_PLANE_COUNT) begin
        planes[cfg_index] <= cfg_data[PLANE_W-1:0];
      end else if (cfg_index == REG_PLANE_COUNT) begin
        plane_count <= cfg_data[CNT_W-1:0];
      end else if (cfg_index == REG_TEST_MODE) begin
        test_mode <= cfg_data[0];
      end
    end
  end

  // ---------------- state machine ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state_next != state || state == ST_IDLE || state == ST_FIN) begin
        step <= '0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_xfer) state_next = (s_axis_tuser == REQ_ROW) ? ST_ROW : ST_XFORM;
      end
      ST_ROW: begin
        if (step == ROW_LAST) state_next = ST_IDLE;
      end
      ST_XFORM: begin
        if (step == XFORM_LAST) state_next = ST_PLANE;
      end
      ST_PLANE: begin
        if (step == PLANE_LAST) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!last_q || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- item capture ----------------
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      req_q  <= s_axis_tuser;
      row_q  <= s_axis_tdata[ROW_LSB +: 2];
      last_q <= s_axis_tlast;
      for (int i = 0; i < 4; i++) word_q[i] <= s_axis_tdata[WORD_LSB + WORD_W*i +: WORD_W];
    end
  end

  // ---------------- matrix memory ----------------
  assign mem_we    = (state == ST_ROW) && (req_q == REQ_ROW);
  assign mem_waddr = {row_q, step[1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) mtx_mem[mem_waddr] <= word_q[step[1:0]];
    rd_data_q    <= mtx_mem[step[3:0]];
    rd_written_q <= mtx_written[step[3:0]];
  end

  // entries never written read as identity
  always_ff @(posedge clk) begin
    if (rst) begin
      mtx_written <= '0;
    end else if (mem_we) begin
      mtx_written[mem_waddr] <= 1'b1;
    end
  end

  // ---------------- transform: T[r] = sum_c M[r][c] * V[c] ----------------
  always_comb begin
    if (rd_written_q) begin
      m_val = rd_data_q;
    end else begin
      m_val = (s1_addr[3:2] == s1_addr[1:0]) ? ONE_Q16 : '0;
    end
    case (s1_addr[1:0])
      2'd0:    v_sel = word_q[0];
      2'd1:    v_sel = word_q[1];
      2'd2:    v_sel = word_q[2];
      default: v_sel = ONE_Q16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_XFORM) && (step < XFORM_ISS);
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= step[3:0];
    s2_addr <= s1_addr;
    prod    <= m_val * v_sel;
    if (s2_valid) begin
      xf_t[s2_addr[3:2]] <= ((s2_addr[1:0] == 2'd0) ? {T_W{1'b0}} : xf_t[s2_addr[3:2]])
                            + {{(T_W-2*WORD_W){prod[2*WORD_W-1]}}, prod};
    end
  end

  // ---------------- plane dots ----------------
  assign pl_issue  = (state == ST_PLANE) && (step < PLANE_ISS);
  assign pl_k      = step[4:2];
  assign pl_r      = step[1:0];
  assign plane_sel = planes[pl_k];
  assign coef      = plane_sel[{pl_r, 4'b0000} +: COEF_W];
  assign t_sel     = xf_t[pl_r];
  assign t_hi      = t_sel[T_W-1:33];
  assign t_lo      = {1'b0, t_sel[32:0]};

  always_comb begin
    case (pl_r)
      2'd0:    v_pl = word_q[0];
      2'd1:    v_pl = word_q[1];
      2'd2:    v_pl = word_q[2];
      default: v_pl = ONE_Q16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= pl_issue;
    end
  end

  always_ff @(posedge clk) begin
    ph  <= coef * t_hi;
    pl  <= coef * t_lo;
    pv  <= coef * v_pl;
    b_k <= pl_k;
    b_r <= pl_r;
  end

  // coef * T split as (coef * T_hi) << 33 + coef * T_lo
  assign term_h = {ph[48], ph, 33'd0};
  assign term_l = {{(ACC_W-50){pl[49]}}, pl};
  assign sum_t  = ((b_r == 2'd0) ? {ACC_W{1'b0}} : acc_t) + term_h + term_l;
  assign sum_v  = ((b_r == 2'd0) ? {DOT_W{1'b0}} : acc_v) + {{(DOT_W-48){pv[47]}}, pv};

  always_ff @(posedge clk) begin
    if (b_valid) begin
      acc_t <= sum_t;
      acc_v <= sum_v;
    end
  end

  // ---------------- set flags and result ----------------
  always_comb begin
    for (int i = 0; i < MAX_PLANES; i++) need[i] = (CNT_W'(i) < count_eff);
    rejected_new = rejected || (outside_cnt == count_eff);
    vis_bit      = test_mode ? !rejected_new : ((inside_flags & need) == need);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_flags <= '0;
      rejected     <= 1'b0;
      outside_cnt  <= '0;
    end else begin
      if (s_xfer) outside_cnt <= '0;
      if (b_valid && b_r == 2'd3) begin
        if (!sum_t[ACC_W-1]) inside_flags[b_k] <= 1'b1;
        if (b_k < count_eff && sum_v[DOT_W-1]) outside_cnt <= outside_cnt + 1'b1;
      end
      if (state == ST_FIN && state_next == ST_IDLE) begin
        if (last_q) begin
          inside_flags <= '0;
          rejected     <= 1'b0;
        end else begin
          rejected <= rejected_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FIN && last_q && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && last_q && out_free) m_vis <= vis_bit;
  end

endmodule

// File: test/tb_frustum_plane_cull.sv
`timescale 1ns / 100ps

module tb_frustum_plane_cull;
  import fpc_pkg::*;

  class cull_scoreboard;
    logic [PLANE_W-1:0]       plane [MAX_PLANES];
    logic [CNT_W-1:0]         count;
    logic                     mode;
    logic signed [WORD_W-1:0] mtx [16];
    logic [MAX_PLANES-1:0]    in_flags;
    logic                     rejected;
    logic                     visible_q [$];
    int                       errors;

    function new();
      for (int i = 0; i < MAX_PLANES; i++) plane[i] = '0;
      for (int i = 0; i < 16; i++) mtx[i] = (i % 5 == 0) ? ONE_Q16 : '0;
      count    = '0;
      mode     = 1'b0;
      in_flags = '0;
      rejected = 1'b0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_PLANE_COUNT) count = data[CNT_W-1:0];
      else if (idx == REG_TEST_MODE) mode = data[0];
      else plane[idx] = data;
    endfunction

    function void note_item(logic req, logic [1:0] row, logic [WORD_W-1:0] w0,
                            logic [WORD_W-1:0] w1, logic [WORD_W-1:0] w2,
                            logic [WORD_W-1:0] w3, logic last);
      logic signed [WORD_W-1:0] v [4];
      logic signed [COEF_W-1:0] cf;
      logic signed [127:0]      acc;
      logic signed [63:0]       dot;
      logic [MAX_PLANES:0]      need;
      int                       n_en;
      int                       outside;
      if (req == REQ_ROW) begin
        mtx[4*row]   = w0;
        mtx[4*row+1] = w1;
        mtx[4*row+2] = w2;
        mtx[4*row+3] = w3;
        return;
      end
      v[0] = w0;
      v[1] = w1;
      v[2] = w2;
      v[3] = ONE_Q16;
      n_en = (count > MAX_PLANES) ? MAX_PLANES : count;
      outside = 0;
      for (int k = 0; k < MAX_PLANES; k++) begin
        acc = '0;
        dot = '0;
        for (int r = 0; r < 4; r++) begin
          cf  = plane[k][16*r +: 16];
          dot = dot + cf * v[r];
          for (int c = 0; c < 4; c++) acc = acc + cf * mtx[4*r+c] * v[c];
        end
        if (!acc[127]) in_flags[k] = 1'b1;
        if (k < n_en && dot < 0) outside++;
      end
      if (outside == n_en) rejected = 1'b1;
      if (last) begin
        need = (MAX_PLANES+1)'((1 << n_en) - 1);
        visible_q.push_back(mode ? !rejected
                                 : ((in_flags & need[MAX_PLANES-1:0]) == need[MAX_PLANES-1:0]));
        in_flags = '0;
        rejected = 1'b0;
      end
    endfunction

    function void check_visible(logic [M_TDATA_W-1:0] data);
      logic exp_vis;
      if (visible_q.size() == 0) begin
        $display("%0t: result with nothing pending, visible %b", $time, data[0]);
        errors++;
      end else begin
        exp_vis = visible_q.pop_front();
        if (data[0] !== exp_vis) begin
          $display("%0t: visible mismatch, expected %b, actual %b", $time, exp_vis, data[0]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return visible_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  cull_scoreboard         sb;
  int                     tx_idle_pct = 0;
  int                     rx_idle_pct = 0;
  logic [PLANE_W-1:0]     cur_plane [MAX_PLANES];
  logic [CNT_W-1:0]       cur_count;
  logic                   cur_mode;

  frustum_plane_cull i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.set_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(s_axis_tuser, s_axis_tdata[ROW_LSB +: 2],
                     s_axis_tdata[WORD_LSB +: 32], s_axis_tdata[WORD_LSB+32 +: 32],
                     s_axis_tdata[WORD_LSB+64 +: 32], s_axis_tdata[WORD_LSB+96 +: 32],
                     s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_visible(m_axis_tdata);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    logic [31:0] s;
    s = $urandom;
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5:    return {{12{s[19]}}, s[19:0]};
      default: return s;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    logic [31:0] s;
    s = $urandom;
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return {{12{s[3]}}, s[3:0]};
      default: return s[15:0];
    endcase
  endfunction

  task automatic send_item(input logic req, input logic [1:0] row,
                           input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                           input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3,
                           input logic last);
    int gap;
    gap = 0;
    // long gaps so that they land on every step of the block's work
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 50);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, w3, w2, w1, w0, row};
    s_axis_tuser  <= req;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_vertex(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
                             input logic [WORD_W-1:0] z, input logic last);
    send_item(REQ_VERTEX, 2'($urandom_range(3)), x, y, z, $urandom, last);
  endtask

  task automatic send_row(input logic [1:0] row, input logic [WORD_W-1:0] w0,
                          input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                          input logic [WORD_W-1:0] w3);
    send_item(REQ_ROW, row, w0, w1, w2, w3, 1'($urandom_range(1)));
  endtask

  task automatic load_identity();
    for (int r = 0; r < 4; r++)
      send_row(2'(r), (r == 0) ? ONE_Q16 : '0, (r == 1) ? ONE_Q16 : '0,
               (r == 2) ? ONE_Q16 : '0, (r == 3) ? ONE_Q16 : '0);
  endtask

  // drain: no transfer in flight and the block past its longest item
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic apply_setting();
    for (int k = 0; k < MAX_PLANES; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(k);
      cfg_data  <= cur_plane[k];
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= REG_PLANE_COUNT;
    cfg_data  <= CFG_DATA_W'(cur_count);
    @(posedge clk);
    cfg_index <= REG_TEST_MODE;
    cfg_data  <= CFG_DATA_W'(cur_mode);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n_items;
    int n_vtx;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no planes, mode 0, identity
    send_vertex(rand_word(), rand_word(), rand_word(), 1'b1);
    quiesce();

    // extreme planes and matrix, count above the plane limit
    cur_plane[0] = {4{16'h7fff}};
    cur_plane[1] = {4{16'h8000}};
    cur_plane[2] = '0;
    cur_plane[3] = {16'h8000, 16'h7fff, 16'h0001, 16'hffff};
    cur_plane[4] = 64'h0000_0000_0000_0001;
    cur_plane[5] = 64'h0000_0000_0000_ffff;
    cur_count    = 3'd7;
    cur_mode     = 1'b0;
    apply_setting();
    send_row(2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_row(2'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_row(2'd2, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
    send_item(REQ_ROW, 2'd3, 32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
    quiesce();

    // untransformed test with no planes enabled culls everything
    cur_count = 3'd0;
    cur_mode  = 1'b1;
    apply_setting();
    load_identity();
    send_vertex(rand_word(), rand_word(), rand_word(), 1'b1);
    quiesce();

    cur_count = 3'd6;
    apply_setting();
    send_vertex(32'hfff0_0000, rand_word(), rand_word(), 1'b0);
    send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
    quiesce();

    // mode switched in the middle of a set: the mode at the last vertex decides
    cur_count = 3'd2;
    cur_mode  = 1'b0;
    apply_setting();
    send_vertex(rand_word(), rand_word(), rand_word(), 1'b0);
    quiesce();
    cur_mode = 1'b1;
    apply_setting();
    send_vertex(rand_word(), rand_word(), rand_word(), 1'b1);
    quiesce();

    for (int ph = 0; ph < 24; ph++) begin
      tx_idle_pct = (ph < 8) ? 24 : (ph < 16) ? 50 : 0;
      rx_idle_pct = (ph < 8) ? 50 : (ph < 16) ? 24 : 0;
      for (int k = 0; k < MAX_PLANES; k++)
        cur_plane[k] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      case ($urandom_range(4))
        0:       cur_count = 3'd0;
        1:       cur_count = 3'd6;
        2:       cur_count = 3'd7;
        default: cur_count = 3'($urandom_range(1, 5));
      endcase
      cur_mode = 1'($urandom_range(1));
      apply_setting();
      if ($urandom_range(3) == 0) load_identity();
      n_items = 0;
      while (n_items < 76) begin
        n_vtx = $urandom_range(1, 6);
        for (int j = 0; j < n_vtx; j++) begin
          // occasional matrix update, also in the middle of a set
          if ($urandom_range(19) == 0) begin
            send_row(2'($urandom_range(3)), rand_word(), rand_word(), rand_word(), rand_word());
            n_items++;
          end
          send_vertex(rand_word(), rand_word(), rand_word(), j == n_vtx - 1);
          n_items++;
        end
      end
      quiesce();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_frustum_plane_cull: clean");
    end else begin
      $display("tb_frustum_plane_cull: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_frustum_plane_cull: errors");
    $finish;
  end

endmodule
